### rtl/gregorian_date_add_days_core_assert.svh
// Assertion macros shared by the date adder modules.
// Included by the controller and datapath; depends on nothing else.
`ifndef GREGORIAN_DATE_ADD_DAYS_CORE_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDAD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gdad: same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GDAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gdad: next-cycle assertion failed");

`endif

### rtl/gdad_pkg.sv
// Shared widths, constants, calendar functions and control structs of the date adder.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package gdad_pkg;

   localparam int YearW  = 14;
   localparam int MonthW = 4;
   localparam int DayW   = 5;
   localparam int AddW   = 20;
   // Offset from the first of the month: day - 1 plus the full day count.
   localparam int OffW   = 21;
   // Year split as century and year within the century.
   localparam int CentW  = 8;
   localparam int YrcW   = 7;
   localparam int ProdW  = 27;
   localparam int YlenW  = 9;

   localparam logic [YearW-1:0]  MaxYear    = 14'd9999;
   localparam logic [MonthW-1:0] MonthJan   = 4'd1;
   localparam logic [MonthW-1:0] MonthDec   = 4'd12;
   localparam logic [DayW-1:0]   LastDecDay = 5'd31;
   localparam logic [YrcW-1:0]   LastYrc    = 7'd99;
   localparam logic [YlenW-1:0]  CommonYear = 9'd365;

   // Reciprocal of 100 scaled by 2^19; exact floor for every 14-bit year.
   localparam logic [12:0] Recip100   = 13'd5243;
   localparam int          RecipShift = 19;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic prep_q;
      logic prep_r;
      logic check;
      logic step;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic walk_done;
      logic out_free;
   } status_type;

   // Leap year from century and year within century (100 is a multiple of 4).
   function automatic logic is_leap(input logic [CentW-1:0] cent,
                                    input logic [YrcW-1:0] yrc);
      logic leap;
      if (yrc == '0) begin
         leap = (cent[1:0] == 2'b00);
      end else begin
         leap = (yrc[1:0] == 2'b00);
      end
      return leap;
   endfunction

   // Length of a month; codes outside 1..12 read as 31 and are caught elsewhere.
   function automatic logic [DayW-1:0] days_in_month(input logic leap,
                                                     input logic [MonthW-1:0] month);
      logic [DayW-1:0] len;
      case (month) inside
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         4'd2:                    len = leap ? 5'd29 : 5'd28;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

### rtl/gdad_chan_if.sv
// Valid/ready channel interfaces for the date adder request and response.
// Depends on gdad_pkg for the field widths.
`timescale 1ns / 1ps

interface gdad_req_if;
   import gdad_pkg::*;

   logic              valid;
   logic              ready;
   logic [YearW-1:0]  start_year;
   logic [MonthW-1:0] start_month;
   logic [DayW-1:0]   start_day;
   logic [AddW-1:0]   days_to_add;

   modport source (output valid, output start_year, output start_month,
                   output start_day, output days_to_add, input ready);
   modport sink   (input valid, input start_year, input start_month,
                   input start_day, input days_to_add, output ready);
endinterface

interface gdad_rsp_if;
   import gdad_pkg::*;

   logic              valid;
   logic              ready;
   logic [YearW-1:0]  result_year;
   logic [MonthW-1:0] result_month;
   logic [DayW-1:0]   result_day;
   logic              year_overflow;
   logic              bad_input;

   modport source (output valid, output result_year, output result_month,
                   output result_day, output year_overflow, output bad_input,
                   input ready);
   modport sink   (input valid, input result_year, input result_month,
                   input result_day, input year_overflow, input bad_input,
                   output ready);
endinterface

### rtl/gdad_ctrl.sv
// Sequencing state machine of the date adder: accept, prepare, check, walk, deliver.
// Depends on gdad_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "gregorian_date_add_days_core_assert.svh"

module gdad_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  gdad_pkg::status_type status,
   output gdad_pkg::cmd_type    cmd
);
   import gdad_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_PREP_Q = 6'b000010,
      ST_PREP_R = 6'b000100,
      ST_CHECK  = 6'b001000,
      ST_WALK   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A new request is taken only between items.
   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP_Q;
            end
         end
         ST_PREP_Q: begin
            cmd.prep_q = 1'b1;
            state_in   = ST_PREP_R;
         end
         ST_PREP_R: begin
            cmd.prep_r = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_WALK;
         end
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_DONE: begin
            // Hand the result over once the output register is free.
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A result that cannot be handed over keeps the machine waiting.
   `GDAD_ASSERT_NEXT(a_done_waits, clock, reset,
      (state_ff == ST_DONE) && !status.out_free, state_ff == ST_DONE)
   // An unfinished walk keeps stepping.
   `GDAD_ASSERT_NEXT(a_walk_continues, clock, reset,
      (state_ff == ST_WALK) && !status.walk_done, state_ff == ST_WALK)
   // An accepted request always starts the year split.
   `GDAD_ASSERT_NEXT(a_load_starts_split, clock, reset, cmd.load, state_ff == ST_PREP_Q)

endmodule

### rtl/gdad_dp.sv
// Datapath of the date adder: operand registers, year split, validity check,
// year and month walk, and the response register. Depends on gdad_pkg,
// the channel interfaces and the assertion macro header.
`timescale 1ns / 1ps
`include "gregorian_date_add_days_core_assert.svh"

module gdad_dp (
   input  logic                 clock,
   input  logic                 reset,
   gdad_req_if.sink             req_chan,
   gdad_rsp_if.source           rsp_chan,
   input  gdad_pkg::cmd_type    cmd,
   output gdad_pkg::status_type status
);
   import gdad_pkg::*;

   // Working registers.
   logic [YearW-1:0]  y_ff, y_in;
   logic [MonthW-1:0] m_ff, m_in;
   logic [DayW-1:0]   d_ff, d_in;
   logic [AddW-1:0]   add_ff, add_in;
   logic [OffW-1:0]   off_ff, off_in;
   logic [CentW-1:0]  cent_ff, cent_in;
   logic [YrcW-1:0]   yrc_ff, yrc_in;
   logic              bad_ff, bad_in;
   logic              ovf_ff, ovf_in;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [YearW-1:0]  res_year_ff, res_year_in;
   logic [MonthW-1:0] res_month_ff, res_month_in;
   logic [DayW-1:0]   res_day_ff, res_day_in;
   logic              res_ovf_ff, res_ovf_in;
   logic              res_bad_ff, res_bad_in;

   logic [ProdW-1:0]  recip_prod;
   logic [YearW-1:0]  yrc_full;
   logic              leap;
   logic [DayW-1:0]   mlen;
   logic [YlenW-1:0]  ylen;
   logic              bad_date;
   logic              year_skip;
   logic              month_step;
   logic              walk_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         bad_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         bad_ff       <= bad_in;
         ovf_ff       <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff         <= y_in;
      m_ff         <= m_in;
      d_ff         <= d_in;
      add_ff       <= add_in;
      off_ff       <= off_in;
      cent_ff      <= cent_in;
      yrc_ff       <= yrc_in;
      res_year_ff  <= res_year_in;
      res_month_ff <= res_month_in;
      res_day_ff   <= res_day_in;
      res_ovf_ff   <= res_ovf_in;
      res_bad_ff   <= res_bad_in;
   end

   // Century by multiplication with the reciprocal, remainder from the registered century.
   assign recip_prod = ProdW'(y_ff) * ProdW'(Recip100);
   assign yrc_full   = y_ff - (YearW'(cent_ff) * 14'd100);

   // Calendar facts of the current year and month.
   assign leap = is_leap(cent_ff, yrc_ff);
   assign mlen = days_in_month(leap, m_ff);
   assign ylen = CommonYear + YlenW'(leap);

   assign bad_date = (y_ff > MaxYear) || (m_ff == '0) || (m_ff > MonthDec) ||
                     (d_ff == '0) || (d_ff > mlen);

   // A whole year is skipped from January; otherwise one month at a time.
   assign year_skip  = (m_ff == MonthJan) && (off_ff >= OffW'(ylen));
   assign month_step = (off_ff >= OffW'(mlen));
   assign walk_done  = bad_ff || ovf_ff || !(year_skip || month_step);

   assign status.walk_done = walk_done;
   assign status.out_free  = !rsp_valid_ff || rsp_chan.ready;

   // Next values of the working registers.
   always_comb begin
      y_in    = y_ff;
      m_in    = m_ff;
      d_in    = d_ff;
      add_in  = add_ff;
      off_in  = off_ff;
      cent_in = cent_ff;
      yrc_in  = yrc_ff;
      bad_in  = bad_ff;
      ovf_in  = ovf_ff;

      if (cmd.load) begin
         y_in   = req_chan.start_year;
         m_in   = req_chan.start_month;
         d_in   = req_chan.start_day;
         add_in = req_chan.days_to_add;
      end

      if (cmd.prep_q) begin
         cent_in = recip_prod[RecipShift +: CentW];
      end

      if (cmd.prep_r) begin
         yrc_in = yrc_full[YrcW-1:0];
      end

      if (cmd.check) begin
         bad_in = bad_date;
         ovf_in = 1'b0;
         off_in = OffW'(d_ff) - OffW'(1) + OffW'(add_ff);
      end

      if (cmd.step && !walk_done) begin
         if (year_skip) begin
            off_in = off_ff - OffW'(ylen);
         end else begin
            off_in = off_ff - OffW'(mlen);
            if (m_ff == MonthDec) begin
               m_in = MonthJan;
            end else begin
               m_in = m_ff + MonthW'(1);
            end
         end
         // Entering the next year, either by a skip or by leaving December.
         if (year_skip || (m_ff == MonthDec)) begin
            if (y_ff == MaxYear) begin
               ovf_in = 1'b1;
            end else begin
               y_in = y_ff + YearW'(1);
               if (yrc_ff == LastYrc) begin
                  yrc_in  = '0;
                  cent_in = cent_ff + CentW'(1);
               end else begin
                  yrc_in = yrc_ff + YrcW'(1);
               end
            end
         end
      end
   end

   // Response register: load on finish, drop once the transfer completes.
   always_comb begin
      res_year_in  = res_year_ff;
      res_month_in = res_month_ff;
      res_day_in   = res_day_ff;
      res_ovf_in   = res_ovf_ff;
      res_bad_in   = res_bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         res_bad_in   = bad_ff;
         res_ovf_in   = ovf_ff && !bad_ff;
         if (bad_ff) begin
            res_year_in  = y_ff;
            res_month_in = m_ff;
            res_day_in   = d_ff;
         end else if (ovf_ff) begin
            res_year_in  = MaxYear;
            res_month_in = MonthDec;
            res_day_in   = LastDecDay;
         end else begin
            res_year_in  = y_ff;
            res_month_in = m_ff;
            res_day_in   = off_ff[DayW-1:0] + DayW'(1);
         end
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.result_year   = res_year_ff;
   assign rsp_chan.result_month  = res_month_ff;
   assign rsp_chan.result_day    = res_day_ff;
   assign rsp_chan.year_overflow = res_ovf_ff;
   assign rsp_chan.bad_input     = res_bad_ff;

   // A finished walk leaves an offset inside the current month.
   `GDAD_ASSERT_SAME(a_offset_in_month, clock, reset,
      cmd.finish && !bad_ff && !ovf_ff, off_ff < OffW'(mlen))
   // The century split follows the year throughout the walk.
   `GDAD_ASSERT_SAME(a_split_tracks_year, clock, reset,
      cmd.step && !bad_ff,
      (y_ff <= MaxYear) && ((YearW'(cent_ff) * 14'd100 + YearW'(yrc_ff)) == y_ff))
   // Handing over a result always raises the response valid.
   `GDAD_ASSERT_NEXT(a_finish_sets_valid, clock, reset, cmd.finish, rsp_valid_ff)

endmodule

### rtl/gregorian_date_add_days_core.sv
// Adds a day count to a Gregorian date (years 0 to 9999, proleptic calendar).
// A request is taken only while no item is in progress. Each item passes
// through acceptance, the split of the year into century and year, the date
// check, the walk of one calendar step per cycle, a state that sees the walk
// has ended and the response load, plus any wait for the output register to
// free. A step is one whole year when the walk stands in January with at least
// a year left, otherwise one month, so steps come to about days_to_add / 365
// plus up to 22 months; the single subtract-and-compare of the walk sets this.
// Invalid dates take no calendar step and finish with bad_input set and the
// fields echoed; a walk past 9999-12-31 saturates there with year_overflow set.
// The response sits in an output register, so a new request can be taken while
// the previous response waits for its transfer.
// Depends on gdad_pkg, the channel interfaces, gdad_ctrl and gdad_dp.
`timescale 1ns / 1ps

module gregorian_date_add_days_core (
   input  logic       clock,
   input  logic       reset,
   gdad_req_if.sink   req_chan,
   gdad_rsp_if.source rsp_chan
);
   import gdad_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   gdad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Operand registers, calendar walk and response register.
   gdad_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

### test/tb_gregorian_date_add_days_core.sv
// Self-checking testbench for the Gregorian date adder: directed table, then random dates.
// Depends on gdad_pkg, the gdad_req_if / gdad_rsp_if interfaces and the core top level.
`timescale 1ns / 1ps

module tb_gregorian_date_add_days_core;
   import gdad_pkg::*;

   localparam int DirCount      = 25;
   localparam int RandItems     = 800;
   localparam int QuietItems    = 100;
   localparam int PressureItems = 12;
   localparam int RspHoldCycles = 300;
   localparam int DrainCycles   = 50;
   localparam int StallLimit    = 12000;
   localparam int ReportLimit   = 10;

   // Directed rows: year, month, day, days to add, typed flag, then the typed
   // result (year, month, day, overflow, bad input). Rows with a typed flag
   // of zero are checked against the predictor.
   localparam int DirTable [DirCount][10] = '{
      '{    0,  1,  1,       0, 1,    0,  1,  1, 0, 0},
      '{ 9999, 12, 31,       0, 1, 9999, 12, 31, 0, 0},
      '{ 9999, 12, 31,       1, 1, 9999, 12, 31, 1, 0},
      '{ 9999, 12, 31, 1048575, 1, 9999, 12, 31, 1, 0},
      '{ 9999,  1,  1,     364, 1, 9999, 12, 31, 0, 0},
      '{ 9999,  1,  1,     365, 1, 9999, 12, 31, 1, 0},
      '{    0,  1,  1, 1048575, 0,    0,  0,  0, 0, 0},
      '{ 2021,  1, 10,      21, 1, 2021,  1, 31, 0, 0},
      '{ 2021,  1, 10,      22, 1, 2021,  2,  1, 0, 0},
      '{ 1999, 12, 31,       1, 1, 2000,  1,  1, 0, 0},
      '{ 2000,  2, 28,       1, 1, 2000,  2, 29, 0, 0},
      '{ 1900,  2, 28,       1, 1, 1900,  3,  1, 0, 0},
      '{    0,  2, 28,       1, 1,    0,  2, 29, 0, 0},
      '{ 2024,  2, 29,     366, 0,    0,  0,  0, 0, 0},
      '{ 2000,  2, 29,       0, 1, 2000,  2, 29, 0, 0},
      '{ 1900,  2, 29,       5, 1, 1900,  2, 29, 0, 1},
      '{ 2023,  2, 29,       0, 1, 2023,  2, 29, 0, 1},
      '{ 2021,  4, 31,       1, 1, 2021,  4, 31, 0, 1},
      '{ 2000,  0, 15,       5, 1, 2000,  0, 15, 0, 1},
      '{ 2000, 13,  1,       5, 1, 2000, 13,  1, 0, 1},
      '{16383, 15, 31, 1048575, 1,16383, 15, 31, 0, 1},
      '{10000,  1,  1,       0, 1,10000,  1,  1, 0, 1},
      '{ 2000,  6,  0,       3, 1, 2000,  6,  0, 0, 1},
      '{ 2100, 12, 31,      60, 0,    0,  0,  0, 0, 0},
      '{ 8191, 12,  1,  123456, 0,    0,  0,  0, 0, 0}
   };

   typedef struct packed {
      logic [YearW-1:0]  year;
      logic [MonthW-1:0] month;
      logic [DayW-1:0]   day;
      logic [AddW-1:0]   span;
   } date_req_type;

   typedef struct packed {
      logic [YearW-1:0]  year;
      logic [MonthW-1:0] month;
      logic [DayW-1:0]   day;
      logic              overflow;
      logic              bad;
   } date_rsp_type;

   logic clock;
   logic reset;

   gdad_req_if req_bus ();
   gdad_rsp_if rsp_bus ();

   gregorian_date_add_days_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   date_rsp_type pending_dates [$];
   int unsigned  fault_count;
   int unsigned  stall_cycles;
   logic         typed_known;
   date_rsp_type typed_result;
   logic         quiet_phase;
   logic         rsp_hold_request;

   // Gregorian leap rule: every fourth year, except centuries not divisible by 400.
   function automatic int unsigned month_length(input int unsigned yr, input int unsigned mo);
      logic leap;
      leap = (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
      case (mo)
         4, 6, 9, 11: return 30;
         2:           return leap ? 29 : 28;
         default:     return 31;
      endcase
   endfunction

   // Walks the calendar month by month from the start date.
   function automatic date_rsp_type calc_date_sum(input date_req_type item);
      int unsigned  yr;
      int unsigned  mo;
      int unsigned  offset;
      date_rsp_type res;
      yr  = item.year;
      mo  = item.month;
      res = '0;
      if (yr > 9999 || mo < 1 || mo > 12 || item.day == '0
          || item.day > month_length(yr, mo)) begin
         res.year  = item.year;
         res.month = item.month;
         res.day   = item.day;
         res.bad   = 1'b1;
         return res;
      end
      offset = int'(item.day) - 1 + int'(item.span);
      while (offset >= month_length(yr, mo)) begin
         offset -= month_length(yr, mo);
         mo++;
         if (mo > 12) begin
            mo = 1;
            yr++;
            if (yr > 9999) begin
               res.year     = MaxYear;
               res.month    = MonthDec;
               res.day      = LastDecDay;
               res.overflow = 1'b1;
               return res;
            end
         end
      end
      res.year  = YearW'(yr);
      res.month = MonthW'(mo);
      res.day   = DayW'(offset + 1);
      return res;
   endfunction

   // Mostly well-formed dates with a spread of day counts; the rest is raw noise.
   function automatic date_req_type make_random_date();
      date_req_type item;
      int unsigned  yr;
      int unsigned  mo;
      int unsigned  dy;
      int unsigned  len;
      int unsigned  pick;
      if ($urandom_range(0, 99) < 15) begin
         item.year  = YearW'($urandom_range(0, 16383));
         item.month = MonthW'($urandom_range(0, 15));
         item.day   = DayW'($urandom_range(0, 31));
         item.span  = AddW'($urandom_range(0, 2000));
         return item;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         yr = $urandom_range(0, 9999);
      end else if (pick < 60) begin
         yr = 100 * $urandom_range(0, 99);
      end else if (pick < 75) begin
         yr = $urandom_range(9980, 9999);
      end else if (pick < 85) begin
         yr = $urandom_range(0, 20);
      end else begin
         yr = $urandom_range(8192, 9999);
      end
      mo  = $urandom_range(1, 12);
      len = month_length(yr, mo);
      dy  = $urandom_range(1, len);
      item.year  = YearW'(yr);
      item.month = MonthW'(mo);
      item.day   = DayW'(dy);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         item.span = AddW'($urandom_range(0, 400));
      end else if (pick < 70) begin
         item.span = AddW'($urandom_range(0, 40000));
      end else if (pick < 78) begin
         item.span = AddW'($urandom);
      end else if (pick < 90) begin
         // Land on the last day of the month, or the first of the next.
         item.span = AddW'(len - dy + $urandom_range(0, 1));
      end else if (pick < 95) begin
         item.span = AddW'(365 * $urandom_range(1, 10) + $urandom_range(0, 2) - 1);
      end else begin
         item.span = AddW'($urandom_range(0, 31));
      end
      return item;
   endfunction

   // Offers one date and waits for its transfer; valid stays high afterwards.
   task automatic offer_date(input date_req_type item, input logic known,
                             input date_rsp_type typed);
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.start_year  <= item.year;
      req_bus.start_month <= item.month;
      req_bus.start_day   <= item.day;
      req_bus.days_to_add <= item.span;
      typed_known  = known;
      typed_result = typed;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
   endtask

   // Lowers valid for a number of cycles, with junk on the payload.
   task automatic pause_requests(input int unsigned cycles);
      @(negedge clock);
      req_bus.valid       <= 1'b0;
      req_bus.start_year  <= YearW'($urandom);
      req_bus.start_month <= MonthW'($urandom);
      req_bus.start_day   <= DayW'($urandom);
      req_bus.days_to_add <= AddW'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_for_drain();
      while (pending_dates.size() != 0) @(posedge clock);
   endtask

   // Compares a transferred result with the oldest expectation.
   task automatic check_result();
      date_rsp_type got;
      date_rsp_type want;
      got.year     = rsp_bus.result_year;
      got.month    = rsp_bus.result_month;
      got.day      = rsp_bus.result_day;
      got.overflow = rsp_bus.year_overflow;
      got.bad      = rsp_bus.bad_input;
      if (pending_dates.size() == 0) begin
         fault_count++;
         if (fault_count <= ReportLimit) begin
            $display("Unexpected result %0d-%0d-%0d ovf=%0b bad=%0b", got.year, got.month,
                     got.day, got.overflow, got.bad);
         end
      end else begin
         want = pending_dates.pop_front();
         if (got !== want) begin
            fault_count++;
            if (fault_count <= ReportLimit) begin
               $display({"Mismatch: expected %0d-%0d-%0d ovf=%0b bad=%0b, ",
                         "got %0d-%0d-%0d ovf=%0b bad=%0b"},
                        want.year, want.month, want.day, want.overflow, want.bad,
                        got.year, got.month, got.day, got.overflow, got.bad);
            end
         end
      end
   endtask

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Expectations are queued on each request transfer and consumed on each result transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            if (typed_known) begin
               pending_dates.push_back(typed_result);
            end else begin
               pending_dates.push_back(calc_date_sum('{req_bus.start_year, req_bus.start_month,
                                                       req_bus.start_day, req_bus.days_to_add}));
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_result();
         end
      end
   end

   // Watchdog on cycles without any transfer on either channel.
   initial begin
      stall_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= StallLimit) begin
            $display("Timeout: no transfer for %0d cycles", StallLimit);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Result side: random back-pressure bursts, one long hold-off on request.
   initial begin
      rsp_bus.ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (RspHoldCycles - 1) @(negedge clock);
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Reset, request stimulus and the end of the run.
   initial begin
      date_req_type item;
      date_rsp_type typed;
      fault_count         = 0;
      typed_known         = 1'b0;
      typed_result        = '0;
      quiet_phase         = 1'b0;
      rsp_hold_request    = 1'b0;
      req_bus.valid       = 1'b0;
      req_bus.start_year  = '0;
      req_bus.start_month = '0;
      req_bus.start_day   = '0;
      req_bus.days_to_add = '0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table.
      for (int i = 0; i < DirCount; i++) begin
         item.year      = YearW'(DirTable[i][0]);
         item.month     = MonthW'(DirTable[i][1]);
         item.day       = DayW'(DirTable[i][2]);
         item.span      = AddW'(DirTable[i][3]);
         typed.year     = YearW'(DirTable[i][5]);
         typed.month    = MonthW'(DirTable[i][6]);
         typed.day      = DayW'(DirTable[i][7]);
         typed.overflow = DirTable[i][8] != 0;
         typed.bad      = DirTable[i][9] != 0;
         offer_date(item, DirTable[i][4] != 0, typed);
         if ($urandom_range(0, 2) == 0) begin
            pause_requests($urandom_range(1, 4));
         end
      end

      // The sender stops until every result is back.
      pause_requests(1);
      wait_for_drain();

      // Long receiver hold-off while short items keep coming, so the input stalls.
      rsp_hold_request = 1'b1;
      for (int i = 0; i < PressureItems; i++) begin
         item      = make_random_date();
         item.span = AddW'($urandom_range(0, 30));
         offer_date(item, 1'b0, '0);
      end

      // Random part; the last stretch runs without idling on either side.
      for (int i = 0; i < RandItems; i++) begin
         if (i == RandItems - QuietItems) begin
            quiet_phase = 1'b1;
         end
         offer_date(make_random_date(), 1'b0, '0);
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            pause_requests($urandom_range(1, 4));
         end
      end

      pause_requests(1);
      wait_for_drain();
      repeat (DrainCycles) @(posedge clock);
      if (fault_count == 0 && pending_dates.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/gdad_pkg.sv
rtl/gdad_chan_if.sv
rtl/gdad_ctrl.sv
rtl/gdad_dp.sv
rtl/gregorian_date_add_days_core.sv
test/tb_gregorian_date_add_days_core.sv
